// ----- sv/llbh_pkg.sv -----
package llbh_pkg;

    // Fixed widths of the configuration registers.
    localparam int THR_W     = 12;
    localparam int MARGIN_W  = 10;
    localparam int DEB_W     = 10;
    localparam int HOLD_W    = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_ADDR_W = 3;

    // Reset values of the configuration registers.
    localparam logic [THR_W-1:0]    THR_RESET    = 12'd2048;
    localparam logic [MARGIN_W-1:0] MARGIN_RESET = 10'd50;
    localparam logic [DEB_W-1:0]    DEB_RESET    = 10'd50;
    localparam logic [HOLD_W-1:0]   HOLD_RESET   = 16'd2500;

    // Configuration register indexes.
    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_DARK_THRESHOLD    = 3'd0,
        REG_HYSTERESIS_MARGIN = 3'd1,
        REG_DEBOUNCE_MS       = 3'd2,
        REG_DARK_HOLD_MS      = 3'd3,
        REG_AUTO_ENABLE       = 3'd4
    } reg_idx_t;

    // Event codes reported with each result.
    typedef enum logic [1:0] {
        EV_NONE = 2'd0,
        EV_OFF  = 2'd1,
        EV_ON   = 2'd2
    } event_t;

    // Current configuration as seen by the datapath.
    typedef struct packed {
        logic [THR_W-1:0]    dark_threshold;
        logic [MARGIN_W-1:0] hysteresis_margin;
        logic [DEB_W-1:0]    debounce_ms;
        logic [HOLD_W-1:0]   dark_hold_ms;
        logic                auto_enable;
    } cfg_t;

    // Single-bit controller state.
    typedef struct packed {
        logic last_below;
        logic last_above;
        logic dark_latched;
        logic light_on;
    } flags_t;

    localparam flags_t FLAGS_RESET = '{
        last_below:   1'b0,
        last_above:   1'b0,
        dark_latched: 1'b0,
        light_on:     1'b1
    };

endpackage

// ----- sv/llbh_cfg.sv -----
module llbh_cfg
    import llbh_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Register decode; writes to unused indexes are dropped.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            unique case (reg_idx_t'(cfg_addr))
                REG_DARK_THRESHOLD:    cfg_next.dark_threshold    = cfg_wdata[THR_W-1:0];
                REG_HYSTERESIS_MARGIN: cfg_next.hysteresis_margin = cfg_wdata[MARGIN_W-1:0];
                REG_DEBOUNCE_MS:       cfg_next.debounce_ms       = cfg_wdata[DEB_W-1:0];
                REG_DARK_HOLD_MS:      cfg_next.dark_hold_ms      = cfg_wdata[HOLD_W-1:0];
                REG_AUTO_ENABLE:       cfg_next.auto_enable       = cfg_wdata[0];
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.dark_threshold    <= THR_RESET;
            cfg_reg.hysteresis_margin <= MARGIN_RESET;
            cfg_reg.debounce_ms       <= DEB_RESET;
            cfg_reg.dark_hold_ms      <= HOLD_RESET;
            cfg_reg.auto_enable       <= 1'b1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- sv/llbh_step.sv -----
module llbh_step
    import llbh_pkg::*;
#(
    parameter int SAMPLE_BITS = 12,
    parameter int COUNT_BITS  = 16
)
(
    input  cfg_t                   cfg,
    input  logic [SAMPLE_BITS-1:0] sample,
    input  flags_t                 flags,
    input  logic [COUNT_BITS-1:0]  stable_count,
    input  logic [COUNT_BITS-1:0]  dwell_count,
    output flags_t                 flags_out,
    output logic [COUNT_BITS-1:0]  stable_count_out,
    output logic [COUNT_BITS-1:0]  dwell_count_out,
    output event_t                 event_out
);

    // Comparison width covers both the sample and threshold plus margin.
    localparam int CMP_W = ((SAMPLE_BITS > THR_W) ? SAMPLE_BITS : THR_W) + 1;
    // Counter compare width covers both the counters and the hold time.
    localparam int CNT_W = (COUNT_BITS > HOLD_W) ? COUNT_BITS : HOLD_W;

    logic [CMP_W-1:0]      full_scale;
    logic [CMP_W-1:0]      sample_ext;
    logic [THR_W-1:0]      lo_raw;
    logic [CMP_W-1:0]      lo_level;
    logic [CMP_W-1:0]      hi_raw;
    logic [CMP_W-1:0]      hi_level;
    logic                  below;
    logic                  above;
    logic [COUNT_BITS-1:0] stable_inc;
    logic [COUNT_BITS-1:0] dwell_inc;
    logic                  debounced;
    logic                  dwell_expired;

    // Dark and light levels, floored at zero and capped at full scale.
    always_comb
    begin
        full_scale = {{(CMP_W-SAMPLE_BITS){1'b0}}, {SAMPLE_BITS{1'b1}}};
        sample_ext = CMP_W'(sample);
        lo_raw     = (cfg.dark_threshold > THR_W'(cfg.hysteresis_margin))
                     ? cfg.dark_threshold - THR_W'(cfg.hysteresis_margin)
                     : '0;
        lo_level   = CMP_W'(lo_raw);
        hi_raw     = CMP_W'(cfg.dark_threshold) + CMP_W'(cfg.hysteresis_margin);
        hi_level   = (hi_raw > full_scale) ? full_scale : hi_raw;
        below      = (sample_ext <= lo_level);
        above      = (sample_ext >= hi_level);
    end

    // Saturating tick counters.
    assign stable_inc = (stable_count == '1) ? stable_count : stable_count + 1'b1;
    assign dwell_inc  = (dwell_count == '1) ? dwell_count : dwell_count + 1'b1;

    // One tick of the controller: darkness entry, then switch off, then light return.
    always_comb
    begin
        flags_out        = flags;
        stable_count_out = stable_inc;
        dwell_count_out  = dwell_inc;
        event_out        = EV_NONE;
        debounced        = 1'b0;
        dwell_expired    = 1'b0;
        if (cfg.auto_enable)
        begin
            if ((below != flags.last_below) || (above != flags.last_above))
            begin
                stable_count_out = '0;
            end
            debounced = (CNT_W'(stable_count_out) > CNT_W'(cfg.debounce_ms));
            if (debounced)
            begin
                if (below && !flags_out.dark_latched)
                begin
                    flags_out.dark_latched = 1'b1;
                    dwell_count_out        = '0;
                end
                dwell_expired = (CNT_W'(dwell_count_out) > CNT_W'(cfg.dark_hold_ms));
                if (below && flags_out.dark_latched && dwell_expired && flags_out.light_on)
                begin
                    flags_out.light_on = 1'b0;
                    event_out          = EV_OFF;
                end
                if (above && flags_out.dark_latched)
                begin
                    flags_out.dark_latched = 1'b0;
                    if (dwell_expired && !flags_out.light_on)
                    begin
                        flags_out.light_on = 1'b1;
                        event_out          = EV_ON;
                    end
                end
            end
            flags_out.last_below = below;
            flags_out.last_above = above;
        end
    end

endmodule

// ----- sv/light_level_backlight_hysteresis.sv -----
// Channel   Direction  Handshake            Payload
// input     in         in_valid / in_ready  sample
// output    out        out_valid/out_ready  backlight_on, in_dark, event_res
// config    in         cfg_wr_en            cfg_addr, cfg_wdata
//
// One transaction is accepted per clock cycle while the output is not stalled. The
// input register captures the sample on acceptance, and the result register captures
// the outcome once it is empty or its result is taken, which makes the result valid.
// The controller state updates in the cycle a sample moves from the input
// register into the result register, so consecutive ticks chain with no gap.
// Reset restores the configuration registers, the handshake state and the
// controller state; payload registers are not reset and no clearing pass is needed.
// A stalled output holds its result while the input register keeps one more sample.
module light_level_backlight_hysteresis
    import llbh_pkg::*;
#(
    parameter int SAMPLE_BITS = 12,
    parameter int COUNT_BITS  = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [SAMPLE_BITS-1:0] sample,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic                   backlight_on,
    output logic                   in_dark,
    output logic [1:0]             event_res
);

    cfg_t                   cfg;
    logic                   a_valid_reg;
    logic [SAMPLE_BITS-1:0] a_sample_reg;
    logic                   out_valid_reg;
    logic                   backlight_on_reg;
    logic                   in_dark_reg;
    event_t                 event_reg;
    flags_t                 flags_reg;
    flags_t                 flags_next;
    logic [COUNT_BITS-1:0]  stable_count_reg;
    logic [COUNT_BITS-1:0]  stable_count_next;
    logic [COUNT_BITS-1:0]  dwell_count_reg;
    logic [COUNT_BITS-1:0]  dwell_count_next;
    event_t                 event_next;
    logic                   advance;
    logic                   in_take;

    llbh_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    llbh_step #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_step (
        .cfg              (cfg),
        .sample           (a_sample_reg),
        .flags            (flags_reg),
        .stable_count     (stable_count_reg),
        .dwell_count      (dwell_count_reg),
        .flags_out        (flags_next),
        .stable_count_out (stable_count_next),
        .dwell_count_out  (dwell_count_next),
        .event_out        (event_next)
    );

    // Pipeline flow: the result register frees up when empty or taken.
    assign advance  = a_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !a_valid_reg || advance;
    assign in_take  = in_valid && in_ready;

    // Control state and controller state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg      <= 1'b0;
            out_valid_reg    <= 1'b0;
            flags_reg        <= FLAGS_RESET;
            stable_count_reg <= '0;
            dwell_count_reg  <= '0;
        end
        else
        begin
            if (in_take)
            begin
                a_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                a_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg    <= 1'b1;
                flags_reg        <= flags_next;
                stable_count_reg <= stable_count_next;
                dwell_count_reg  <= dwell_count_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            a_sample_reg <= sample;
        end
        if (advance)
        begin
            backlight_on_reg <= flags_next.light_on;
            in_dark_reg      <= flags_next.dark_latched;
            event_reg        <= event_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign backlight_on = backlight_on_reg;
    assign in_dark      = in_dark_reg;
    assign event_res    = event_reg;

endmodule

// ----- sv/llbh_checker.sv -----
module llbh_checker
    import llbh_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic       backlight_on,
    input logic       in_dark,
    input logic [1:0] event_res
);

    // A stalled result transaction keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(backlight_on) && $stable(in_dark)
            && $stable(event_res))
    else $error("result payload changed while stalled");

    // A switch-off event leaves the backlight off and the room dark.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (event_res == EV_OFF) |-> !backlight_on && in_dark)
    else $error("switch-off event with inconsistent state");

    // A switch-on event leaves the backlight on and the dark state cleared.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (event_res == EV_ON) |-> backlight_on && !in_dark)
    else $error("switch-on event with inconsistent state");

endmodule

bind light_level_backlight_hysteresis llbh_checker u_llbh_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .backlight_on (backlight_on),
    .in_dark      (in_dark),
    .event_res    (event_res)
);

// ----- bench/tb_light_level_backlight_hysteresis.sv -----
`timescale 1ns / 100ps

module tb_light_level_backlight_hysteresis;
    import llbh_pkg::*;

    localparam int SAMPLE_W   = 12;
    localparam int COUNT_W    = 16;
    localparam int FULL_SCALE = (1 << SAMPLE_W) - 1;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam int IDLE_LIMIT = 2000;
    localparam int END_WAIT   = 10;
    localparam int SOAK_TICKS = 450;
    localparam int PHASE_TICKS = 165;
    localparam int NUM_PHASES = 8;
    localparam int NROWS      = 26;

    // One expected result transaction.
    typedef struct packed {
        logic   lamp;
        logic   dark;
        event_t ev;
    } tick_result_t;

    typedef enum logic [1:0] {
        ROW_TICK,
        ROW_FAST_CFG,
        ROW_AUTO_OFF,
        ROW_AUTO_ON
    } row_kind_t;

    typedef struct packed {
        row_kind_t           kind;
        logic [SAMPLE_W-1:0] smp;
        logic                typed;
        tick_result_t        want;
    } plan_row_t;

    typedef enum {
        ZONE_DARK,
        ZONE_LIGHT,
        ZONE_EDGE,
        ZONE_MID,
        ZONE_NOISE
    } zone_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_wr_en;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  in_valid;
    logic                  in_ready;
    logic [SAMPLE_W-1:0]   sample;
    logic                  out_valid;
    logic                  out_ready;
    logic                  backlight_on;
    logic                  in_dark;
    logic [1:0]            event_res;

    // Controller copy: configuration.
    logic [THR_W-1:0]    cfg_thr;
    logic [MARGIN_W-1:0] cfg_margin;
    logic [DEB_W-1:0]    cfg_deb;
    logic [HOLD_W-1:0]   cfg_hold;
    logic                cfg_auto;

    // Controller copy: state.
    logic               was_below;
    logic               was_above;
    logic               dark_held;
    logic               lamp_on;
    logic [COUNT_W-1:0] stable_ms;
    logic [COUNT_W-1:0] dwell_ms;

    tick_result_t        expected_results[$];
    tick_result_t        want_res;
    logic [MARGIN_W-1:0] tie_val;
    int                  src_idle_pct;
    int                  sink_stall_pct;
    int                  errors;
    int                  ticks_sent;
    int                  results_seen;
    int                  off_events;
    int                  on_events;
    int                  idle_cycles;

    // Directed walk: reset values, then a fast configuration that reaches
    // every transition within a few ticks, then a frozen stretch.
    plan_row_t plan_rows [NROWS] = '{
        '{ROW_TICK,     12'd0,    1'b1, '{1'b1, 1'b0, EV_NONE}},
        '{ROW_TICK,     12'd0,    1'b1, '{1'b1, 1'b0, EV_NONE}},
        '{ROW_TICK,     12'd4095, 1'b1, '{1'b1, 1'b0, EV_NONE}},
        '{ROW_FAST_CFG, 12'd0,    1'b0, '{1'b0, 1'b0, EV_NONE}},
        '{ROW_TICK,     12'd4095, 1'b1, '{1'b1, 1'b0, EV_NONE}},
        '{ROW_TICK,     12'd0,    1'b1, '{1'b1, 1'b0, EV_NONE}},
        '{ROW_TICK,     12'd0,    1'b1, '{1'b1, 1'b1, EV_NONE}},
        '{ROW_TICK,     12'd0,    1'b1, '{1'b0, 1'b1, EV_OFF}},
        '{ROW_TICK,     12'd0,    1'b1, '{1'b0, 1'b1, EV_NONE}},
        '{ROW_TICK,     12'd4095, 1'b1, '{1'b0, 1'b1, EV_NONE}},
        '{ROW_TICK,     12'd4095, 1'b1, '{1'b1, 1'b0, EV_ON}},
        '{ROW_TICK,     12'd0,    1'b1, '{1'b1, 1'b0, EV_NONE}},
        '{ROW_TICK,     12'd0,    1'b1, '{1'b1, 1'b1, EV_NONE}},
        '{ROW_TICK,     12'd2048, 1'b1, '{1'b1, 1'b1, EV_NONE}},
        '{ROW_TICK,     12'd2048, 1'b1, '{1'b1, 1'b0, EV_ON}},
        '{ROW_TICK,     12'd2047, 1'b0, '{1'b0, 1'b0, EV_NONE}},
        '{ROW_TICK,     12'd2049, 1'b0, '{1'b0, 1'b0, EV_NONE}},
        '{ROW_TICK,     12'hAAA,  1'b0, '{1'b0, 1'b0, EV_NONE}},
        '{ROW_TICK,     12'h555,  1'b0, '{1'b0, 1'b0, EV_NONE}},
        '{ROW_AUTO_OFF, 12'd0,    1'b0, '{1'b0, 1'b0, EV_NONE}},
        '{ROW_TICK,     12'd0,    1'b0, '{1'b0, 1'b0, EV_NONE}},
        '{ROW_TICK,     12'd4095, 1'b0, '{1'b0, 1'b0, EV_NONE}},
        '{ROW_TICK,     12'd2048, 1'b0, '{1'b0, 1'b0, EV_NONE}},
        '{ROW_AUTO_ON,  12'd0,    1'b0, '{1'b0, 1'b0, EV_NONE}},
        '{ROW_TICK,     12'd0,    1'b0, '{1'b0, 1'b0, EV_NONE}},
        '{ROW_TICK,     12'd0,    1'b0, '{1'b0, 1'b0, EV_NONE}}
    };

    light_level_backlight_hysteresis #(
        .SAMPLE_BITS (SAMPLE_W),
        .COUNT_BITS  (COUNT_W)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .sample       (sample),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .backlight_on (backlight_on),
        .in_dark      (in_dark),
        .event_res    (event_res)
    );

    always #5 clk = ~clk;

    // Dark level: threshold minus margin, floored at zero.
    function automatic int dark_level();
        return (cfg_thr > cfg_margin) ? int'(cfg_thr) - int'(cfg_margin) : 0;
    endfunction

    // Light level: threshold plus margin, capped at full scale.
    function automatic int light_level();
        int sum;
        sum = int'(cfg_thr) + int'(cfg_margin);
        return (sum > FULL_SCALE) ? FULL_SCALE : sum;
    endfunction

    // Advance the controller copy by one millisecond tick.
    function automatic tick_result_t predict_tick(logic [SAMPLE_W-1:0] s);
        tick_result_t res;
        logic         below;
        logic         above;
        res.ev = EV_NONE;
        if (stable_ms != COUNT_MAX)
            stable_ms = stable_ms + 1'b1;
        if (dwell_ms != COUNT_MAX)
            dwell_ms = dwell_ms + 1'b1;
        if (cfg_auto)
        begin
            below = (int'(s) <= dark_level());
            above = (int'(s) >= light_level());
            if (below != was_below || above != was_above)
                stable_ms = '0;
            if (stable_ms > cfg_deb)
            begin
                // Entry into darkness, then switch-off, then return of light.
                if (below && !dark_held)
                begin
                    dark_held = 1'b1;
                    dwell_ms  = '0;
                end
                if (below && dark_held && dwell_ms > cfg_hold && lamp_on)
                begin
                    lamp_on = 1'b0;
                    res.ev  = EV_OFF;
                end
                if (above && dark_held)
                begin
                    dark_held = 1'b0;
                    if (dwell_ms > cfg_hold && !lamp_on)
                    begin
                        lamp_on = 1'b1;
                        res.ev  = EV_ON;
                    end
                end
            end
            was_below = below;
            was_above = above;
        end
        res.lamp = lamp_on;
        res.dark = dark_held;
        return res;
    endfunction

    // Pick a sample inside a region relative to the current levels.
    function automatic logic [SAMPLE_W-1:0] pick_sample(zone_t zone);
        int lo;
        int hi;
        lo = dark_level();
        hi = light_level();
        case (zone)
            ZONE_DARK:  return SAMPLE_W'($urandom_range(lo, 0));
            ZONE_LIGHT: return SAMPLE_W'($urandom_range(FULL_SCALE, hi));
            ZONE_EDGE:
            begin
                case ($urandom_range(2))
                    0:       return SAMPLE_W'(lo);
                    1:       return SAMPLE_W'(hi);
                    default: return cfg_thr;
                endcase
            end
            ZONE_MID:
            begin
                if (hi - lo > 1)
                    return SAMPLE_W'($urandom_range(hi - 1, lo + 1));
                return SAMPLE_W'($urandom);
            end
            default:    return SAMPLE_W'($urandom);
        endcase
    endfunction

    // Offer one sample; called and returning at a falling edge.
    task automatic send_tick(logic [SAMPLE_W-1:0] s, logic typed, tick_result_t typed_res);
        tick_result_t model_res;
        while ($urandom_range(99) < src_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        sample   <= s;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        model_res = predict_tick(s);
        expected_results.push_back(typed ? typed_res : model_res);
        ticks_sent++;
        @(negedge clk);
    endtask

    // Hold the sender off until every expected result has arrived.
    task automatic drain_results();
        in_valid <= 1'b0;
        @(negedge clk);
        while (expected_results.size() != 0)
            @(negedge clk);
    endtask

    // One register write; the enable stays high for back-to-back writes.
    task automatic write_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        case (addr)
            REG_DARK_THRESHOLD:    cfg_thr    = data[THR_W-1:0];
            REG_HYSTERESIS_MARGIN: cfg_margin = data[MARGIN_W-1:0];
            REG_DEBOUNCE_MS:       cfg_deb    = data[DEB_W-1:0];
            REG_DARK_HOLD_MS:      cfg_hold   = data[HOLD_W-1:0];
            REG_AUTO_ENABLE:       cfg_auto   = data[0];
            default:               ;
        endcase
        @(negedge clk);
    endtask

    // Full reprogramming with junk in the unused upper bits and the spare indexes.
    task automatic set_config(logic [THR_W-1:0] thr, logic [MARGIN_W-1:0] margin,
                              logic [DEB_W-1:0] deb, logic [HOLD_W-1:0] hold, logic en);
        drain_results();
        write_reg(REG_DARK_THRESHOLD, {4'($urandom), thr});
        write_reg(REG_HYSTERESIS_MARGIN, {6'($urandom), margin});
        write_reg(REG_DEBOUNCE_MS, {6'($urandom), deb});
        write_reg(REG_DARK_HOLD_MS, hold);
        write_reg(REG_AUTO_ENABLE, {15'($urandom), en});
        for (int k = int'(REG_AUTO_ENABLE) + 1; k < (1 << CFG_ADDR_W); k++)
            write_reg(CFG_ADDR_W'(k), CFG_DATA_W'($urandom));
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_auto(logic en);
        drain_results();
        write_reg(REG_AUTO_ENABLE, {15'($urandom), en});
        cfg_wr_en <= 1'b0;
    endtask

    // Runs of samples that hold one region long enough to pass debounce and
    // dwell, mixed with short glitches and noise.
    task automatic run_random(int n, logic pause_midway);
        int    sent;
        int    len;
        int    r;
        zone_t zone;
        sent = 0;
        while (sent < n)
        begin
            r = $urandom_range(99);
            zone = (r < 35) ? ZONE_DARK : (r < 70) ? ZONE_LIGHT :
                   (r < 85) ? ZONE_EDGE : (r < 92) ? ZONE_MID : ZONE_NOISE;
            if ($urandom_range(4) == 0)
                len = $urandom_range(int'(cfg_deb) + 1, 1);
            else
                len = $urandom_range(int'(cfg_deb) + int'(cfg_hold) + 10, int'(cfg_deb) + 1);
            for (int i = 0; i < len && sent < n; i++)
            begin
                send_tick(pick_sample(zone), 1'b0, '0);
                sent++;
                if (pause_midway && sent == n / 2)
                    drain_results();
            end
        end
    endtask

    // Receiver stalls are redrawn every cycle.
    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= sink_stall_pct);

    // Compare each result transaction with the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (expected_results.size() == 0)
            begin
                errors++;
                $display("%0t: result with none expected: on=%0d dark=%0d event=%0d",
                         $time, backlight_on, in_dark, event_res);
            end
            else
            begin
                want_res = expected_results.pop_front();
                if (want_res.ev == EV_OFF)
                    off_events++;
                if (want_res.ev == EV_ON)
                    on_events++;
                if (backlight_on !== want_res.lamp || in_dark !== want_res.dark ||
                    event_res !== want_res.ev)
                begin
                    errors++;
                    $display("%0t: mismatch: expected on=%0d dark=%0d event=%0d,",
                             $time, want_res.lamp, want_res.dark, want_res.ev);
                    $display("    got on=%0d dark=%0d event=%0d",
                             backlight_on, in_dark, event_res);
                end
            end
        end
    end

    // Watchdog on cycles without any transaction or register write.
    always @(posedge clk)
    begin
        if (!rst_n || cfg_wr_en || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
            $display("[light_level_backlight_hysteresis] ERROR");
            $finish;
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_addr       = '0;
        cfg_wdata      = '0;
        in_valid       = 1'b0;
        sample         = '0;
        out_ready      = 1'b0;
        tie_val        = '0;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        errors         = 0;
        ticks_sent     = 0;
        results_seen   = 0;
        off_events     = 0;
        on_events      = 0;
        idle_cycles    = 0;

        // Controller copy starts from the reset values.
        cfg_thr    = THR_RESET;
        cfg_margin = MARGIN_RESET;
        cfg_deb    = DEB_RESET;
        cfg_hold   = HOLD_RESET;
        cfg_auto   = 1'b1;
        was_below  = FLAGS_RESET.last_below;
        was_above  = FLAGS_RESET.last_above;
        dark_held  = FLAGS_RESET.dark_latched;
        lamp_on    = FLAGS_RESET.light_on;
        stable_ms  = '0;
        dwell_ms   = '0;

        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed table.
        foreach (plan_rows[r])
        begin
            case (plan_rows[r].kind)
                ROW_FAST_CFG: set_config(12'd2048, 10'd0, 10'd0, 16'd0, 1'b1);
                ROW_AUTO_OFF: set_auto(1'b0);
                ROW_AUTO_ON:  set_auto(1'b1);
                default:
                    send_tick(plan_rows[r].smp, plan_rows[r].typed, plan_rows[r].want);
            endcase
        end

        // Long darkness with a long hold: the backlight goes off only once the
        // dwell passes the hold, and returning light brings it back after debounce.
        set_config(12'd2048, 10'd100, 10'd20, 16'd400, 1'b1);
        for (int i = 0; i < SOAK_TICKS; i++)
            send_tick(pick_sample(ZONE_DARK), 1'b0, '0);
        for (int i = 0; i < 60; i++)
            send_tick(pick_sample(ZONE_LIGHT), 1'b0, '0);

        // Random phases over level extremes and idle patterns.
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            case (ph)
                0: set_config(12'($urandom), 10'($urandom_range(200)), 10'd0, 16'd0, 1'b1);
                1: set_config(12'd0, 10'd1023, 10'($urandom_range(3)),
                              16'($urandom_range(30)), 1'b1);
                2: set_config(12'd4095, 10'd1023, 10'd1, 16'($urandom_range(10)), 1'b1);
                3: set_config(12'd4095, 10'd0, 10'($urandom_range(5)),
                              16'($urandom_range(20)), 1'b1);
                4: set_config(12'($urandom), 10'd0, 10'd0, 16'd0, 1'b1);
                5: set_config(12'($urandom), 10'($urandom), 10'($urandom_range(6)),
                              16'($urandom_range(30)), 1'b0);
                6: set_config(12'($urandom), 10'($urandom), 10'($urandom_range(10)),
                              16'($urandom_range(60)), 1'b1);
                default:
                begin
                    // Margin equal to the threshold puts the dark level at zero.
                    tie_val = 10'($urandom_range(1023));
                    set_config(THR_W'(tie_val), tie_val,
                               10'($urandom_range(8)), 16'($urandom_range(40)), 1'b1);
                end
            endcase
            case (ph % 4)
                0:
                begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 0;
                end
                1:
                begin
                    src_idle_pct   = 61;
                    sink_stall_pct = 0;
                end
                2:
                begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 61;
                end
                default:
                begin
                    src_idle_pct   = 21;
                    sink_stall_pct = 21;
                end
            endcase
            run_random(PHASE_TICKS, ph % 4 == 1);
        end

        drain_results();
        repeat (END_WAIT) @(negedge clk);

        $display("Covered %0d ticks (directed, long dark soak, %0d random phases), %0d results.",
                 ticks_sent, NUM_PHASES, results_seen);
        $display("Saw %0d switch-off and %0d switch-on events; %0d failures.",
                 off_events, on_events, errors);
        if (errors == 0)
            $display("[light_level_backlight_hysteresis] OK");
        else
            $display("[light_level_backlight_hysteresis] ERROR");
        $finish;
    end

endmodule

// ----- sim.f -----
sv/llbh_pkg.sv
sv/llbh_cfg.sv
sv/llbh_step.sv
sv/light_level_backlight_hysteresis.sv
sv/llbh_checker.sv
bench/tb_light_level_backlight_hysteresis.sv
